// ===== sv/qmn_pkg.sv =====
// types and constants shared by the quaternion multiply and normalise pipeline
`default_nettype none

package qmn_pkg;

    localparam int CW     = 16;            // component width
    localparam int PROD_W = 2 * CW;        // one component product
    localparam int SUM_W  = PROD_W + 2;    // sum of four products
    localparam int MAG_W  = SUM_W - 1;     // magnitude of a sum
    localparam int RED_W  = 31;            // magnitude after common reduction
    localparam int SQ_W   = 2 * RED_W + 2; // sum of four squares
    localparam int NCOMP  = 4;             // x, y, z, w

    localparam logic [31:0] POS_LIMIT = 32'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [31:0] NEG_LIMIT = 32'(64'd1 << (CW - 1));

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] first_w;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
        logic signed [CW-1:0] second_w;
    } operand_t;

    typedef struct packed {
        logic signed [CW-1:0] result_x;
        logic signed [CW-1:0] result_y;
        logic signed [CW-1:0] result_z;
        logic signed [CW-1:0] result_w;
        logic                 zero_magnitude;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/qmn_product.sv =====
// hamilton product: component multiplies, then the four signed sums
`default_nettype none

module qmn_product
    import qmn_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    valid_in,
    input  wire operand_t                operands,
    output logic                         valid_out,
    output logic signed [SUM_W-1:0]      sum_out [NCOMP]
);

    logic signed [PROD_W-1:0] prod_reg [16];
    logic signed [PROD_W-1:0] prod_next [16];
    logic signed [SUM_W-1:0]  sum_reg [NCOMP];
    logic signed [SUM_W-1:0]  sum_next [NCOMP];
    logic                     v1_reg;
    logic                     v2_reg;

    always_comb
    begin
        prod_next[0]  = operands.first_x * operands.second_w;
        prod_next[1]  = operands.second_x * operands.first_w;
        prod_next[2]  = operands.second_y * operands.first_z;
        prod_next[3]  = operands.second_z * operands.first_y;
        prod_next[4]  = operands.first_y * operands.second_w;
        prod_next[5]  = operands.second_y * operands.first_w;
        prod_next[6]  = operands.second_z * operands.first_x;
        prod_next[7]  = operands.second_x * operands.first_z;
        prod_next[8]  = operands.first_z * operands.second_w;
        prod_next[9]  = operands.second_z * operands.first_w;
        prod_next[10] = operands.second_x * operands.first_y;
        prod_next[11] = operands.second_y * operands.first_x;
        prod_next[12] = operands.first_w * operands.second_w;
        prod_next[13] = operands.first_x * operands.second_x;
        prod_next[14] = operands.first_y * operands.second_y;
        prod_next[15] = operands.first_z * operands.second_z;
    end

    always_comb
    begin
        sum_next[0] = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) - SUM_W'(prod_reg[3]);
        sum_next[1] = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5])
                    + SUM_W'(prod_reg[6]) - SUM_W'(prod_reg[7]);
        sum_next[2] = SUM_W'(prod_reg[8]) + SUM_W'(prod_reg[9])
                    + SUM_W'(prod_reg[10]) - SUM_W'(prod_reg[11]);
        sum_next[3] = SUM_W'(prod_reg[12]) - SUM_W'(prod_reg[13])
                    - SUM_W'(prod_reg[14]) - SUM_W'(prod_reg[15]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign valid_out = v2_reg;
    assign sum_out   = sum_reg;

endmodule

`default_nettype wire

// ===== sv/qmn_scale.sv =====
// magnitude reduction, squares and set-up of the root search
`default_nettype none

module qmn_scale
    import qmn_pkg::*;
#(
    parameter int FRACTION_BITS = 14,
    localparam int AW = 2 * FRACTION_BITS + 70
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    valid_in,
    input  wire logic signed [SUM_W-1:0] sum_in [NCOMP],
    output logic                         valid_out,
    output logic                         zero_out,
    output logic [SQ_W-1:0]              s_out,
    output logic [NCOMP-1:0]             neg_out,
    output logic signed [AW-1:0]         r_out [NCOMP],
    output logic signed [AW-1:0]         q2_out [NCOMP]
);

    logic [MAG_W-1:0]     mag [NCOMP];
    logic [MAG_W-1:0]     mag_or;
    logic [RED_W-1:0]     red_next [NCOMP];
    logic [RED_W-1:0]     red_reg [NCOMP];
    logic [NCOMP-1:0]     neg_next;
    logic [NCOMP-1:0]     neg3_reg;
    logic [NCOMP-1:0]     neg4_reg;
    logic [NCOMP-1:0]     neg5_reg;
    logic [2*RED_W-1:0]   sq_reg [NCOMP];
    logic [SQ_W-1:0]      s_next;
    logic signed [AW-1:0] s_ext;
    logic signed [AW-1:0] r_next [NCOMP];
    logic signed [AW-1:0] r_reg [NCOMP];
    logic signed [AW-1:0] q2_next;
    logic signed [AW-1:0] q2_reg;
    logic [SQ_W-1:0]      s_reg;
    logic                 zero_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic                 v5_reg;

    // common right shift keeps the largest magnitude below 2^31
    always_comb
    begin
        mag_or = '0;
        for (int i = 0; i < NCOMP; i++)
        begin
            neg_next[i] = sum_in[i][SUM_W-1];
            mag[i] = neg_next[i] ? MAG_W'(-sum_in[i]) : MAG_W'(sum_in[i]);
            mag_or = mag_or | mag[i];
        end
        for (int i = 0; i < NCOMP; i++)
        begin
            if (mag_or[MAG_W-1])
                red_next[i] = RED_W'(mag[i] >> 2);
            else if (mag_or[MAG_W-2])
                red_next[i] = RED_W'(mag[i] >> 1);
            else
                red_next[i] = RED_W'(mag[i]);
        end
    end

    // remainder starts at T - S and the running term at -2S
    always_comb
    begin
        s_next = '0;
        for (int i = 0; i < NCOMP; i++)
            s_next = s_next + SQ_W'(sq_reg[i]);
        s_ext   = signed'(AW'(s_next));
        q2_next = -(s_ext <<< 1);
        for (int i = 0; i < NCOMP; i++)
            r_next[i] = (signed'(AW'(sq_reg[i])) <<< (2 * FRACTION_BITS + 2)) - s_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= valid_in;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg  <= red_next;
        neg3_reg <= neg_next;
        for (int i = 0; i < NCOMP; i++)
            sq_reg[i] <= red_reg[i] * red_reg[i];
        neg4_reg <= neg3_reg;
        r_reg    <= r_next;
        q2_reg   <= q2_next;
        s_reg    <= s_next;
        zero_reg <= (s_next == '0);
        neg5_reg <= neg4_reg;
    end

    assign valid_out = v5_reg;
    assign zero_out  = zero_reg;
    assign s_out     = s_reg;
    assign neg_out   = neg5_reg;
    assign r_out     = r_reg;
    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
            q2_out[i] = q2_reg;
    end

endmodule

`default_nettype wire

// ===== sv/qmn_root_stage.sv =====
// one bit of the rounded m/sqrt(s) search for all four components
`default_nettype none

module qmn_root_stage
    import qmn_pkg::*;
#(
    parameter int FRACTION_BITS = 14,
    parameter int BIT_POS = 0,
    localparam int AW = 2 * FRACTION_BITS + 70,
    localparam int NW = FRACTION_BITS + 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    valid_in,
    input  wire logic                    zero_in,
    input  wire logic [SQ_W-1:0]         s_in,
    input  wire logic [NCOMP-1:0]        neg_in,
    input  wire logic signed [AW-1:0]    r_in [NCOMP],
    input  wire logic signed [AW-1:0]    q2_in [NCOMP],
    input  wire logic [NW-1:0]           n_in [NCOMP],
    output logic                         valid_out,
    output logic                         zero_out,
    output logic [SQ_W-1:0]              s_out,
    output logic [NCOMP-1:0]             neg_out,
    output logic signed [AW-1:0]         r_out [NCOMP],
    output logic signed [AW-1:0]         q2_out [NCOMP],
    output logic [NW-1:0]                n_out [NCOMP]
);

    logic signed [AW-1:0] s_ext;
    logic signed [AW-1:0] delta [NCOMP];
    logic signed [AW-1:0] trial [NCOMP];
    logic signed [AW-1:0] r_next [NCOMP];
    logic signed [AW-1:0] q2_next [NCOMP];
    logic [NW-1:0]        n_next [NCOMP];
    logic signed [AW-1:0] r_reg [NCOMP];
    logic signed [AW-1:0] q2_reg [NCOMP];
    logic [NW-1:0]        n_reg [NCOMP];
    logic [SQ_W-1:0]      s_reg;
    logic [NCOMP-1:0]     neg_reg;
    logic                 zero_reg;
    logic                 valid_reg;

    // r holds T - (2n-1)^2 s, q2 holds (4n-2) s
    always_comb
    begin
        s_ext = signed'(AW'(s_in));
        for (int i = 0; i < NCOMP; i++)
        begin
            delta[i] = (q2_in[i] + (s_ext <<< (BIT_POS + 1))) <<< (BIT_POS + 1);
            trial[i] = r_in[i] - delta[i];
            if (!trial[i][AW-1])
            begin
                r_next[i]  = trial[i];
                q2_next[i] = q2_in[i] + (s_ext <<< (BIT_POS + 2));
                n_next[i]  = n_in[i] | (NW'(1) << BIT_POS);
            end
            else
            begin
                r_next[i]  = r_in[i];
                q2_next[i] = q2_in[i];
                n_next[i]  = n_in[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        q2_reg   <= q2_next;
        n_reg    <= n_next;
        s_reg    <= s_in;
        neg_reg  <= neg_in;
        zero_reg <= zero_in;
    end

    assign valid_out = valid_reg;
    assign zero_out  = zero_reg;
    assign s_out     = s_reg;
    assign neg_out   = neg_reg;
    assign r_out     = r_reg;
    assign q2_out    = q2_reg;
    assign n_out     = n_reg;

endmodule

`default_nettype wire

// ===== sv/quaternion_multiply_normalize.sv =====
// top level: quaternion product normalised to unit magnitude
`default_nettype none

// One word is taken in every clock cycle (busy stays low) and its result
// appears on result with a one-cycle done strobe. Each word passes five
// stages for the products, sums, reduction, squares and set-up, then the
// root search, which settles one bit of each normalised component per
// pipeline stage, and then the output register.
// When the product is exactly zero the components read zero and
// zero_magnitude is set.
module quaternion_multiply_normalize
    import qmn_pkg::*;
#(
    parameter int FRACTION_BITS = 14
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire operand_t operands,
    output logic          done,
    output result_t       result
);

    localparam int AW      = 2 * FRACTION_BITS + 70;
    localparam int NW      = FRACTION_BITS + 1;
    localparam int NSTAGE  = FRACTION_BITS + 1;
    localparam int LATENCY = FRACTION_BITS + 7;

    logic                     prod_valid;
    logic signed [SUM_W-1:0]  sums [NCOMP];

    logic                     ch_valid [NSTAGE+1];
    logic                     ch_zero [NSTAGE+1];
    logic [SQ_W-1:0]          ch_s [NSTAGE+1];
    logic [NCOMP-1:0]         ch_neg [NSTAGE+1];
    logic signed [AW-1:0]     ch_r [NSTAGE+1][NCOMP];
    logic signed [AW-1:0]     ch_q2 [NSTAGE+1][NCOMP];
    logic [NW-1:0]            ch_n [NSTAGE+1][NCOMP];

    logic signed [CW-1:0]     comp [NCOMP];
    logic [31:0]              nval;
    result_t                  result_next;
    result_t                  result_reg;
    logic                     done_reg;

    assign busy = 1'b0;

    qmn_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .operands  (operands),
        .valid_out (prod_valid),
        .sum_out   (sums)
    );

    qmn_scale #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (prod_valid),
        .sum_in    (sums),
        .valid_out (ch_valid[0]),
        .zero_out  (ch_zero[0]),
        .s_out     (ch_s[0]),
        .neg_out   (ch_neg[0]),
        .r_out     (ch_r[0]),
        .q2_out    (ch_q2[0])
    );

    always_comb
    begin
        for (int i = 0; i < NCOMP; i++)
            ch_n[0][i] = '0;
    end

    // most significant bit first
    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_root
        qmn_root_stage #(
            .FRACTION_BITS (FRACTION_BITS),
            .BIT_POS       (FRACTION_BITS - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (ch_valid[g]),
            .zero_in   (ch_zero[g]),
            .s_in      (ch_s[g]),
            .neg_in    (ch_neg[g]),
            .r_in      (ch_r[g]),
            .q2_in     (ch_q2[g]),
            .n_in      (ch_n[g]),
            .valid_out (ch_valid[g+1]),
            .zero_out  (ch_zero[g+1]),
            .s_out     (ch_s[g+1]),
            .neg_out   (ch_neg[g+1]),
            .r_out     (ch_r[g+1]),
            .q2_out    (ch_q2[g+1]),
            .n_out     (ch_n[g+1])
        );
    end

    // sign, saturation and the zero case
    always_comb
    begin
        nval = '0;
        for (int i = 0; i < NCOMP; i++)
        begin
            nval = 32'(ch_n[NSTAGE][i]);
            if (ch_zero[NSTAGE])
                comp[i] = '0;
            else if (ch_neg[NSTAGE][i])
                comp[i] = (nval > NEG_LIMIT) ? -CW'(NEG_LIMIT) : -CW'(nval);
            else
                comp[i] = (nval > POS_LIMIT) ? CW'(POS_LIMIT) : CW'(nval);
        end
        result_next.result_x       = comp[0];
        result_next.result_y       = comp[1];
        result_next.result_z       = comp[2];
        result_next.result_w       = comp[3];
        result_next.zero_magnitude = ch_zero[NSTAGE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ch_valid[NSTAGE];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without a matching input word");

    a_zero_out : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_magnitude) |->
            (result.result_x == '0 && result.result_y == '0 &&
             result.result_z == '0 && result.result_w == '0))
        else $error("zero magnitude word with nonzero components");

    a_unit : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.zero_magnitude) |->
            (result.result_x != '0 || result.result_y != '0 ||
             result.result_z != '0 || result.result_w != '0))
        else $error("normalised word lost all its magnitude");

endmodule

`default_nettype wire
